// File: hdl/drcs_pkg.sv
package drcs_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_PSIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POFFSET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LABEL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LABEL_WR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ERR  = 3'd5;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_IO    = 3'd1;
  localparam logic [2:0] ST_RANGE = 3'd2;
  localparam logic [2:0] ST_LABEL = 3'd3;
  localparam logic [2:0] ST_EOP   = 3'd4;

  // Command kinds, emitted in this order.
  localparam int K_REJ = 0;
  localparam int K_ALN = 1;
  localparam int K_HRD = 2;
  localparam int K_HWR = 3;
  localparam int K_MID = 4;
  localparam int K_TRD = 5;
  localparam int K_TWR = 6;
  localparam int NKIND = 7;

  localparam int AW = 33;

  typedef struct packed {
    logic [31:0] psize;
    logic [31:0] poff;
    logic [2:0]  shift;
    logic [15:0] label;
    logic        label_wr;
    logic        dev_err;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] bn;
    logic [23:0]        bcount;
    logic               rd;
  } req_t;

  typedef struct packed {
    logic [6:0]    bn_low;
    logic [23:0]   bcount;
    logic          rd;
    logic [15:0]   sz;
    logic          neg;
    logic          over;
    logic [33:0]   room;
    logic [AW-1:0] abs0;
    logic [AW-1:0] abs_al;
  } sum_t;

  typedef struct packed {
    logic [2:0]    status;
    logic          rd;
    logic [23:0]   bcount;
    logic          aligned;
    logic          has_head;
    logic [6:0]    bn_low;
    logic [AW-1:0] abs0;
    logic [AW-1:0] abs_al;
  } chk_t;

  typedef struct packed {
    logic [2:0]    status;
    logic          rd;
    logic [23:0]   bcount;
    logic [15:0]   boff;
    logic [AW-1:0] abs0;
    logic [AW-1:0] abs_al;
    logic [AW-1:0] a1;
    logic [16:0]   head_count;
    logic [23:0]   mid_count;
    logic [15:0]   r2;
  } plan_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        is_write;
    logic [31:0] device_block;
    logic [15:0] block_count;
    logic [23:0] transfer_bytes;
    logic        via_bounce;
    logic [15:0] bounce_offset;
    logic [15:0] copy_bytes;
    logic [23:0] user_offset;
    logic        last;
  } cmd_t;

  function automatic logic [16:0] blk_bytes(input logic [2:0] sh);
    return 17'd512 << sh;
  endfunction

  function automatic logic [6:0] low_mask(input logic [2:0] sh);
    return 7'((8'd1 << sh) - 8'd1);
  endfunction

  function automatic logic [31:0] dev_addr(input logic [AW-1:0] a, input logic [2:0] sh);
    return 32'(a >> sh);
  endfunction

  function automatic logic [15:0] blk_count(input logic [23:0] bytes, input logic [2:0] sh);
    return 16'((bytes >> 9) >> sh);
  endfunction

endpackage

// File: hdl/drcs_check.sv
module drcs_check (
  input  logic           clk,
  input  logic           rst,
  input  drcs_pkg::cfg_t cfg,
  input  logic           req_valid,
  output logic           req_ready,
  input  drcs_pkg::req_t req,
  output logic           chk_valid,
  input  logic           chk_ready,
  output drcs_pkg::chk_t chk
);
  import drcs_pkg::*;

  logic [6:0]  lmask;
  logic [15:0] sz;
  sum_t        a_next;
  sum_t        a_q;
  logic        a_valid;
  logic        a_ready;
  chk_t        b_next;
  logic        b_ready;
  logic [15:0] sz_f;
  logic        lab_le;
  logic        lab_gt;
  logic [23:0] mask24;

  assign lmask = low_mask(cfg.shift);
  assign sz = 16'((25'(req.bcount) + 25'd511) >> 9);

  always_comb begin
    a_next.bn_low = req.bn[6:0] & lmask;
    a_next.bcount = req.bcount;
    a_next.rd = req.rd;
    a_next.sz = sz;
    a_next.neg = req.bn[31];
    a_next.over = ({2'b0, req.bn[30:0]} + {17'b0, sz}) > {1'b0, cfg.psize};
    a_next.room = {2'b0, cfg.psize} - {3'b0, req.bn[30:0]};
    a_next.abs0 = {2'b0, req.bn[30:0]} + {1'b0, cfg.poff};
    a_next.abs_al = {2'b0, req.bn[30:7], req.bn[6:0] & ~lmask} + {1'b0, cfg.poff};
  end

  assign sz_f = a_q.over ? a_q.room[15:0] : a_q.sz;
  assign lab_le = a_q.abs0 <= {17'b0, cfg.label};
  assign lab_gt = ({1'b0, a_q.abs0} + {18'b0, sz_f}) > {18'b0, cfg.label};
  assign mask24 = {7'b0, blk_bytes(cfg.shift) - 17'd1};

  always_comb begin
    b_next.rd = a_q.rd;
    b_next.bn_low = a_q.bn_low;
    b_next.abs0 = a_q.abs0;
    b_next.abs_al = a_q.abs_al;
    b_next.bcount = a_q.over ? {a_q.room[14:0], 9'b0} : a_q.bcount;
    b_next.aligned = (a_q.bn_low == 7'd0) && ((b_next.bcount & mask24) == 24'd0);
    b_next.has_head = (a_q.bn_low != 7'd0) ||
                      (b_next.bcount < {7'b0, blk_bytes(cfg.shift)});
    priority if (cfg.dev_err) begin
      b_next.status = ST_IO;
    end else if (a_q.neg) begin
      b_next.status = ST_RANGE;
    end else if (a_q.over && a_q.room[33]) begin
      b_next.status = ST_RANGE;
    end else if (a_q.over && (a_q.room == 34'd0)) begin
      b_next.status = ST_EOP;
    end else if (!a_q.rd && !cfg.label_wr && lab_le && lab_gt) begin
      b_next.status = ST_LABEL;
    end else begin
      b_next.status = ST_OK;
    end
  end

  assign b_ready = !chk_valid || chk_ready;
  assign a_ready = !a_valid || b_ready;
  assign req_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= req_valid;
      end
      if (b_ready) begin
        chk_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && req_valid) begin
      a_q <= a_next;
    end
    if (b_ready && a_valid) begin
      chk <= b_next;
    end
  end

endmodule

// File: hdl/drcs_split.sv
module drcs_split (
  input  logic           clk,
  input  logic           rst,
  input  drcs_pkg::cfg_t cfg,
  input  logic           chk_valid,
  output logic           chk_ready,
  input  drcs_pkg::chk_t chk,
  output logic           done,
  output drcs_pkg::cmd_t cmd
);
  import drcs_pkg::*;

  logic [16:0]      bsize;
  logic [23:0]      mask24;
  logic [7:0]       units;
  logic [15:0]      boff;
  logic [16:0]      head_room;
  logic             over_head;
  logic [23:0]      r1;
  plan_t            plan_new;
  logic [NKIND-1:0] pend_new;
  plan_t            plan;
  logic [NKIND-1:0] pend;
  logic [NKIND-1:0] pend_rest;
  logic             p_free;
  logic [AW-1:0]    a2;
  logic [23:0]      tail_user;
  cmd_t             cmd_next;

  assign bsize = blk_bytes(cfg.shift);
  assign mask24 = {7'b0, bsize - 17'd1};
  assign units = 8'd1 << cfg.shift;
  assign boff = {chk.bn_low, 9'b0};
  assign head_room = bsize - {1'b0, boff};
  assign over_head = chk.bcount > {7'b0, head_room};

  always_comb begin
    if (!chk.has_head) begin
      r1 = chk.bcount;
    end else if (over_head) begin
      r1 = chk.bcount - {7'b0, head_room};
    end else begin
      r1 = 24'd0;
    end
  end

  always_comb begin
    plan_new.status = chk.status;
    plan_new.rd = chk.rd;
    plan_new.bcount = chk.bcount;
    plan_new.boff = boff;
    plan_new.abs0 = chk.abs0;
    plan_new.abs_al = chk.abs_al;
    plan_new.a1 = chk.abs_al + (chk.has_head ? {25'b0, units} : 33'd0);
    if (!chk.has_head) begin
      plan_new.head_count = 17'd0;
    end else if (over_head) begin
      plan_new.head_count = head_room;
    end else begin
      plan_new.head_count = chk.bcount[16:0];
    end
    plan_new.mid_count = r1 & ~mask24;
    plan_new.r2 = r1[15:0] & mask24[15:0];
  end

  always_comb begin
    pend_new = '0;
    if (chk.status != ST_OK) begin
      pend_new[K_REJ] = 1'b1;
    end else if (chk.aligned) begin
      pend_new[K_ALN] = 1'b1;
    end else if (chk.bcount != 24'd0) begin
      pend_new[K_HRD] = chk.has_head;
      pend_new[K_HWR] = chk.has_head && !chk.rd;
      pend_new[K_MID] = plan_new.mid_count != 24'd0;
      pend_new[K_TRD] = plan_new.r2 != 16'd0;
      pend_new[K_TWR] = (plan_new.r2 != 16'd0) && !chk.rd;
    end
  end

  // The lowest pending kind goes out each cycle; with one left the plan can reload.
  assign pend_rest = pend & (pend - 7'd1);
  assign p_free = pend_rest == '0;
  assign chk_ready = p_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      done <= 1'b0;
    end else begin
      done <= pend != '0;
      if (p_free) begin
        pend <= chk_valid ? pend_new : '0;
      end else begin
        pend <= pend_rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_free && chk_valid) begin
      plan <= plan_new;
    end
  end

  assign a2 = plan.a1 + {18'b0, plan.mid_count[23:9]};
  assign tail_user = {7'b0, plan.head_count} + plan.mid_count;

  always_comb begin
    cmd_next = '0;
    cmd_next.last = p_free;
    priority if (pend[K_REJ]) begin
      cmd_next.status = plan.status;
    end else if (pend[K_ALN]) begin
      cmd_next.is_write = !plan.rd;
      cmd_next.device_block = dev_addr(plan.abs0, cfg.shift);
      cmd_next.block_count = blk_count(plan.bcount, cfg.shift);
      cmd_next.transfer_bytes = plan.bcount;
    end else if (pend[K_HRD] || pend[K_HWR]) begin
      cmd_next.is_write = !pend[K_HRD];
      cmd_next.device_block = dev_addr(plan.abs_al, cfg.shift);
      cmd_next.block_count = 16'd1;
      cmd_next.transfer_bytes = {7'b0, bsize};
      cmd_next.via_bounce = 1'b1;
      cmd_next.bounce_offset = plan.boff;
      cmd_next.copy_bytes = plan.head_count[15:0];
    end else if (pend[K_MID]) begin
      cmd_next.is_write = !plan.rd;
      cmd_next.device_block = dev_addr(plan.a1, cfg.shift);
      cmd_next.block_count = blk_count(plan.mid_count, cfg.shift);
      cmd_next.transfer_bytes = plan.mid_count;
      cmd_next.user_offset = {7'b0, plan.head_count};
    end else if (pend[K_TRD] || pend[K_TWR]) begin
      cmd_next.is_write = !pend[K_TRD];
      cmd_next.device_block = dev_addr(a2, cfg.shift);
      cmd_next.block_count = 16'd1;
      cmd_next.transfer_bytes = {7'b0, bsize};
      cmd_next.via_bounce = 1'b1;
      cmd_next.copy_bytes = plan.r2;
      cmd_next.user_offset = tail_user;
    end else begin
      cmd_next.last = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
  end

endmodule

// File: hdl/disk_request_check_and_split.sv
// Channel   Handshake             Payload
// request   start / busy          start_block, byte_count, is_read
// config    cfg_valid / cfg_ready cfg_index, cfg_data
// command   done (strobe)         status .. last, one command per beat
//
// An accepted request yields zero to five command beats, one per cycle, from a
// single output register; the first passes the input register, the check
// stages, the plan register and the output register. A request occupies the
// plan register until its last command goes out. A request that yields no
// command raises no done strobe and leaves the pipeline at the plan register.
// Reset is synchronous and clears the configuration and all valid flags.
// The receiver cannot stall; busy rises only while the command stage is full.
module disk_request_check_and_split (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [31:0]                  start_block,
  input  logic [23:0]                         byte_count,
  input  logic                                is_read,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [drcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data,
  output logic                                done,
  output logic [2:0]                          status,
  output logic                                is_write,
  output logic [31:0]                         device_block,
  output logic [15:0]                         block_count,
  output logic [23:0]                         transfer_bytes,
  output logic                                via_bounce,
  output logic [15:0]                         bounce_offset,
  output logic [15:0]                         copy_bytes,
  output logic [23:0]                         user_offset,
  output logic                                last
);
  import drcs_pkg::*;

  cfg_t cfg;
  req_t s0_req;
  logic s0_valid;
  logic s0_ready;
  logic req_ready;
  logic chk_valid;
  logic chk_ready;
  chk_t chk;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PSIZE:    cfg.psize <= cfg_data;
        CFG_POFFSET:  cfg.poff <= cfg_data;
        CFG_SHIFT:    cfg.shift <= cfg_data[2:0];
        CFG_LABEL:    cfg.label <= cfg_data[15:0];
        CFG_LABEL_WR: cfg.label_wr <= cfg_data[0];
        CFG_DEV_ERR:  cfg.dev_err <= cfg_data[0];
        default:      cfg <= cfg;
      endcase
    end
  end

  assign s0_ready = !s0_valid || req_ready;
  assign busy = !s0_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_ready) begin
      s0_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start && s0_ready) begin
      s0_req.bn <= start_block;
      s0_req.bcount <= byte_count;
      s0_req.rd <= is_read;
    end
  end

  drcs_check u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (s0_valid),
    .req_ready (req_ready),
    .req       (s0_req),
    .chk_valid (chk_valid),
    .chk_ready (chk_ready),
    .chk       (chk)
  );

  drcs_split u_split (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .chk_valid (chk_valid),
    .chk_ready (chk_ready),
    .chk       (chk),
    .done      (done),
    .cmd       (cmd)
  );

  assign status = cmd.status;
  assign is_write = cmd.is_write;
  assign device_block = cmd.device_block;
  assign block_count = cmd.block_count;
  assign transfer_bytes = cmd.transfer_bytes;
  assign via_bounce = cmd.via_bounce;
  assign bounce_offset = cmd.bounce_offset;
  assign copy_bytes = cmd.copy_bytes;
  assign user_offset = cmd.user_offset;
  assign last = cmd.last;

endmodule
